>>> sv/lpmr_pkg.sv
// Shared constants, codes and controller/datapath interface types for the message ring.
package lpmr_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int MAX_MSG    = 64;
    localparam int HDR_BYTES  = 4;
    localparam int CNT_MAX    = 255;

    localparam int OP_W     = 2;
    localparam int LEN_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int STS_W    = 2;
    localparam int FILL_W   = 10;
    localparam int CNT_W    = 8;
    localparam int SUM_W    = ADDR_W + 8;

    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 3;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd1;
    localparam logic [OP_W-1:0] OP_GET   = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_NOSPACE = 2'd1;
    localparam logic [STS_W-1:0] STS_OPEN    = 2'd2;
    localparam logic [STS_W-1:0] STS_EMPTY   = 2'd3;

    typedef struct packed {
        logic exec_simple;  // start, push or no-op taken this cycle
        logic get_empty;    // get with nothing held
        logic get_start;    // get: read header byte
        logic hdr_load;     // header byte is in the read register
        logic byte_emit;    // send one message byte
        logic zero_emit;    // send the zero-length marker
    } t_cmd;

    typedef struct packed {
        logic out_free;     // output register can take a result
        logic msg_none;     // no complete message held
        logic hdr_zero;     // header read gives length zero
        logic rd_last;      // one byte left in the running get
    } t_stat;

endpackage

>>> sv/lpmr_ctrl.sv
// Controller state machine: request intake and get sequencing.
module lpmr_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [lpmr_pkg::OP_W-1:0] i_op,
    input  lpmr_pkg::t_stat        i_stat,
    output lpmr_pkg::t_cmd         o_cmd
);
    import lpmr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HDR  = 4'b0010,
        S_BYTE = 4'b0100,
        S_ZERO = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_s_tready = (r_state == S_IDLE) && i_stat.out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_GET) begin
                        if (i_stat.msg_none) begin
                            o_cmd.get_empty = 1'b1;
                        end else begin
                            o_cmd.get_start = 1'b1;
                            n_state         = S_HDR;
                        end
                    end else begin
                        o_cmd.exec_simple = 1'b1;
                    end
                end
            end
            S_HDR: begin
                o_cmd.hdr_load = 1'b1;
                n_state        = i_stat.hdr_zero ? S_ZERO : S_BYTE;
            end
            S_BYTE: begin
                if (i_stat.out_free) begin
                    o_cmd.byte_emit = 1'b1;
                    if (i_stat.rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ZERO: begin
                if (i_stat.out_free) begin
                    o_cmd.zero_emit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/lpmr_dp.sv
// Datapath: byte ring memory, pointers, message counters and the result register.
module lpmr_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lpmr_pkg::t_cmd              i_cmd,
    output lpmr_pkg::t_stat             o_stat,
    input  logic [lpmr_pkg::OP_W-1:0]   i_op,
    input  logic [lpmr_pkg::LEN_W-1:0]  i_msg_len,
    input  logic [lpmr_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                        i_m_tready,
    output logic                        o_m_tvalid,
    output logic [lpmr_pkg::STS_W-1:0]  o_status,
    output logic [lpmr_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_last_byte,
    output logic                        o_zero_length,
    output logic [lpmr_pkg::FILL_W-1:0] o_fill_level,
    output logic [lpmr_pkg::CNT_W-1:0]  o_messages_held
);
    import lpmr_pkg::*;

    logic [BYTE_W-1:0] r_mem [RING_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    logic [ADDR_W-1:0] r_wp, n_wp;
    logic [ADDR_W-1:0] r_rp, n_rp;
    logic [ADDR_W-1:0] r_raddr, n_raddr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_open, n_open;
    logic [LEN_W-1:0]  r_remain, n_remain;
    logic [LEN_W-1:0]  r_rdlen, n_rdlen;

    logic              r_ovalid, n_ovalid;
    logic [STS_W-1:0]  r_status;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_olast;
    logic              r_ozero;
    logic [FILL_W-1:0] r_ofill;
    logic [CNT_W-1:0]  r_oheld;

    logic              w_we, w_re, w_emit;
    logic [ADDR_W-1:0] w_waddr, w_raddr, w_used, w_fill_next;
    logic [BYTE_W-1:0] w_wdata;
    logic [STS_W-1:0]  w_sts;
    logic [BYTE_W-1:0] w_obyte;
    logic              w_olast, w_ozero;
    logic [LEN_W-1:0]  w_hdr_len;
    logic [SUM_W-1:0]  w_need;
    logic              w_reject;

    assign w_used    = r_wp - r_rp;
    // upper header bytes are skipped, not written; only the low byte is stored and read
    assign w_hdr_len = (r_rdata > BYTE_W'(MAX_MSG)) ? LEN_W'(MAX_MSG) : r_rdata[LEN_W-1:0];
    assign w_need    = SUM_W'(w_used) + SUM_W'(i_msg_len) + SUM_W'(HDR_BYTES);
    assign w_reject  = (i_msg_len > LEN_W'(MAX_MSG)) || (w_need > SUM_W'(RING_DEPTH - 1))
                    || (r_count == CNT_W'(CNT_MAX));

    assign o_stat.out_free = !r_ovalid || i_m_tready;
    assign o_stat.msg_none = (r_count == '0);
    assign o_stat.hdr_zero = (w_hdr_len == '0);
    assign o_stat.rd_last  = (r_rdlen == LEN_W'(1));

    always_comb begin
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_raddr  = r_raddr;
        n_count  = r_count;
        n_open   = r_open;
        n_remain = r_remain;
        n_rdlen  = r_rdlen;
        w_we     = 1'b0;
        w_waddr  = r_wp;
        w_wdata  = '0;
        w_re     = 1'b0;
        w_raddr  = r_rp;
        w_emit   = 1'b0;
        w_sts    = STS_OK;
        w_obyte  = '0;
        w_olast  = 1'b0;
        w_ozero  = 1'b0;

        if (i_cmd.exec_simple) begin
            w_emit = 1'b1;
            unique case (i_op) inside
                OP_START: begin
                    if (r_open) begin
                        w_sts = STS_OPEN;
                    end else if (w_reject) begin
                        w_sts    = STS_NOSPACE;
                        n_remain = i_msg_len;
                    end else begin
                        w_we    = 1'b1;
                        w_wdata = BYTE_W'(i_msg_len);
                        n_wp    = r_wp + ADDR_W'(HDR_BYTES);
                        n_remain = i_msg_len;
                        if (i_msg_len == '0) begin
                            n_count = r_count + CNT_W'(1);
                        end else begin
                            n_open = 1'b1;
                        end
                    end
                end
                OP_PUSH: begin
                    if (r_open) begin
                        w_we     = 1'b1;
                        w_wdata  = i_in_byte;
                        n_wp     = r_wp + ADDR_W'(1);
                        n_remain = r_remain - LEN_W'(1);
                        if (r_remain == LEN_W'(1)) begin
                            n_open  = 1'b0;
                            n_count = r_count + CNT_W'(1);
                        end
                    end else if (r_remain != '0) begin
                        n_remain = r_remain - LEN_W'(1);
                        w_sts    = STS_NOSPACE;
                    end
                end
                OP_GET, OP_NOP: begin
                    w_sts = STS_OK;
                end
                default: begin
                    w_sts = STS_OK;
                end
            endcase
        end

        if (i_cmd.get_empty) begin
            w_emit  = 1'b1;
            w_sts   = STS_EMPTY;
            w_olast = 1'b1;
        end

        if (i_cmd.get_start) begin
            w_re    = 1'b1;
            w_raddr = r_rp;
        end

        // free the whole message now so every byte result carries the final level
        if (i_cmd.hdr_load) begin
            n_rdlen = w_hdr_len;
            n_rp    = r_rp + ADDR_W'(HDR_BYTES) + ADDR_W'(w_hdr_len);
            n_count = r_count - CNT_W'(1);
            w_raddr = r_rp + ADDR_W'(HDR_BYTES);
            n_raddr = r_rp + ADDR_W'(HDR_BYTES + 1);
            w_re    = (w_hdr_len != '0);
        end

        if (i_cmd.byte_emit) begin
            w_emit  = 1'b1;
            w_obyte = r_rdata;
            w_olast = (r_rdlen == LEN_W'(1));
            n_rdlen = r_rdlen - LEN_W'(1);
            if (r_rdlen != LEN_W'(1)) begin
                w_re    = 1'b1;
                w_raddr = r_raddr;
                n_raddr = r_raddr + ADDR_W'(1);
            end
        end

        if (i_cmd.zero_emit) begin
            w_emit  = 1'b1;
            w_olast = 1'b1;
            w_ozero = 1'b1;
        end

        w_fill_next = n_wp - n_rp;
        n_ovalid    = w_emit || (r_ovalid && !i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_count  <= '0;
            r_open   <= 1'b0;
            r_remain <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_count  <= n_count;
            r_open   <= n_open;
            r_remain <= n_remain;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr <= n_raddr;
        r_rdlen <= n_rdlen;
        if (w_emit) begin
            r_status <= w_sts;
            r_obyte  <= w_obyte;
            r_olast  <= w_olast;
            r_ozero  <= w_ozero;
            r_ofill  <= FILL_W'(w_fill_next);
            r_oheld  <= n_count;
        end
    end

    assign o_m_tvalid      = r_ovalid;
    assign o_status        = r_status;
    assign o_out_byte      = r_obyte;
    assign o_last_byte     = r_olast;
    assign o_zero_length   = r_ozero;
    assign o_fill_level    = r_ofill;
    assign o_messages_held = r_oheld;

    a_open_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_remain != '0))
        else $error("open message with no bytes left");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.byte_emit || i_cmd.zero_emit || i_cmd.exec_simple || i_cmd.get_empty)
        |-> o_stat.out_free)
        else $error("result written over a pending one");

    a_rdlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hdr_load |=> (r_rdlen <= LEN_W'(MAX_MSG)))
        else $error("read length above message limit");

endmodule

>>> sv/length_prefixed_message_ring_unit.sv
// Top level of the length-prefixed message ring.
//
//  channel  dir  handshake            payload
//  s_axis   in   i_s_tvalid/o_s_tready  tuser: op; tdata: msg_len, in_byte
//  m_axis   out  o_m_tvalid/i_m_tready  tuser: status, zero_length; tlast: last_byte;
//                                      tdata: out_byte, fill_level, messages_held
//
// Start, push and no-op requests each give one result; pushes stream one per cycle while
// results are taken. A get uses the single read port of the byte RAM: it reads the header
// byte, then the message bytes one by one, or gives one marker result for length zero.
// Reset clears pointers and counters at once; RAM contents stay undefined, no sweep.
// A pending result is held until taken; s_tready is low while it blocks or a get runs.
module length_prefixed_message_ring_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [lpmr_pkg::S_DATA_W-1:0] i_s_tdata,  // [6:0] msg_len, [14:7] in_byte, [15] zero
    input  logic [lpmr_pkg::S_USER_W-1:0] i_s_tuser,  // [1:0] op
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [lpmr_pkg::M_DATA_W-1:0] o_m_tdata,  // [7:0] out_byte, [17:8] fill_level,
                                                     // [25:18] messages_held, [31:26] zero
    output logic [lpmr_pkg::M_USER_W-1:0] o_m_tuser,  // [1:0] status, [2] zero_length
    output logic                          o_m_tlast   // last_byte
);
    import lpmr_pkg::*;

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [STS_W-1:0]  w_status;
    logic [BYTE_W-1:0] w_out_byte;
    logic              w_zero_length;
    logic [FILL_W-1:0] w_fill_level;
    logic [CNT_W-1:0]  w_messages_held;

    lpmr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_op       (i_s_tuser[OP_W-1:0]),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lpmr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_op            (i_s_tuser[OP_W-1:0]),
        .i_msg_len       (i_s_tdata[LEN_W-1:0]),
        .i_in_byte       (i_s_tdata[LEN_W+BYTE_W-1:LEN_W]),
        .i_m_tready      (i_m_tready),
        .o_m_tvalid      (o_m_tvalid),
        .o_status        (w_status),
        .o_out_byte      (w_out_byte),
        .o_last_byte     (o_m_tlast),
        .o_zero_length   (w_zero_length),
        .o_fill_level    (w_fill_level),
        .o_messages_held (w_messages_held)
    );

    assign o_m_tdata = {{(M_DATA_W - BYTE_W - FILL_W - CNT_W){1'b0}},
                        w_messages_held, w_fill_level, w_out_byte};
    assign o_m_tuser = {w_zero_length, w_status};

endmodule

>>> test/lpmr_checker.sv
// Scoreboard for the message ring: tracks both streams, predicts each result and compares.
module lpmr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [lpmr_pkg::S_DATA_W-1:0] i_s_tdata,  // [6:0] msg_len, [14:7] in_byte, [15] zero
    input  logic [lpmr_pkg::S_USER_W-1:0] i_s_tuser,  // [1:0] op
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [lpmr_pkg::M_DATA_W-1:0] i_m_tdata,  // [7:0] out_byte, [17:8] fill_level,
                                                      // [25:18] messages_held, [31:26] zero
    input  logic [lpmr_pkg::M_USER_W-1:0] i_m_tuser,  // [1:0] status, [2] zero_length
    input  logic                          i_m_tlast,  // last_byte
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);
    import lpmr_pkg::*;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
        logic              zero_length;
        logic [FILL_W-1:0] fill_level;
        logic [CNT_W-1:0]  messages_held;
    } t_ring_result;

    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    logic [ADDR_W-1:0] rd_ptr;
    logic [ADDR_W-1:0] wr_ptr;
    logic [CNT_W-1:0]  held_msgs;
    logic              msg_open;
    logic [LEN_W-1:0]  bytes_left;
    t_ring_result      expected_q[$];
    int                fails = 0;
    int                checked = 0;

    // pointer distance wraps at the ring size
    function automatic logic [FILL_W-1:0] ring_used();
        return FILL_W'(wr_ptr - rd_ptr);
    endfunction

    task automatic predict_request(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                                   input logic [BYTE_W-1:0] data);
        t_ring_result      res;
        logic [BYTE_W-1:0] msg_bytes [MAX_MSG];
        int                hdr_len;
        int                k;
        res = '0;
        hdr_len = 0;
        case (op)
            OP_START: begin
                if (msg_open) begin
                    res.status = STS_OPEN;
                end else if (int'(len) > MAX_MSG
                             || int'(ring_used()) + int'(len) + HDR_BYTES > RING_DEPTH - 1
                             || int'(held_msgs) >= CNT_MAX) begin
                    // rejected: the following len data bytes get dropped
                    bytes_left = len;
                    res.status = STS_NOSPACE;
                end else begin
                    for (k = 0; k < HDR_BYTES; k++) begin
                        ring_mem[wr_ptr] = (k == 0) ? BYTE_W'(len) : '0;
                        wr_ptr++;
                    end
                    if (len == 0) begin
                        held_msgs++;
                        bytes_left = '0;
                    end else begin
                        msg_open = 1'b1;
                        bytes_left = len;
                    end
                end
            end
            OP_PUSH: begin
                if (msg_open) begin
                    ring_mem[wr_ptr] = data;
                    wr_ptr++;
                    bytes_left--;
                    if (bytes_left == 0) begin
                        msg_open = 1'b0;
                        held_msgs++;
                    end
                end else if (bytes_left != 0) begin
                    bytes_left--;
                    res.status = STS_NOSPACE;
                end
            end
            OP_GET: begin
                if (held_msgs == 0) begin
                    res.status = STS_EMPTY;
                    res.last_byte = 1'b1;
                end else begin
                    for (k = 0; k < HDR_BYTES; k++) begin
                        hdr_len |= int'(ring_mem[rd_ptr]) << (8 * k);
                        rd_ptr++;
                    end
                    if (hdr_len > MAX_MSG) hdr_len = MAX_MSG;
                    held_msgs--;
                    if (hdr_len == 0) begin
                        res.last_byte = 1'b1;
                        res.zero_length = 1'b1;
                    end
                    for (k = 0; k < hdr_len; k++) begin
                        msg_bytes[k] = ring_mem[rd_ptr];
                        rd_ptr++;
                    end
                end
            end
            default: ;
        endcase
        // levels are those after the whole step, in every result of it
        res.fill_level = ring_used();
        res.messages_held = held_msgs;
        if (hdr_len == 0) begin
            expected_q.push_back(res);
        end else begin
            for (k = 0; k < hdr_len; k++) begin
                res.out_byte = msg_bytes[k];
                res.last_byte = (k == hdr_len - 1);
                expected_q.push_back(res);
            end
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_ring_result got;
        t_ring_result want;
        if (!i_rst_n) begin
            rd_ptr = '0;
            wr_ptr = '0;
            held_msgs = '0;
            msg_open = 1'b0;
            bytes_left = '0;
            expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.status        = i_m_tuser[1:0];
                got.zero_length   = i_m_tuser[2];
                got.last_byte     = i_m_tlast;
                got.out_byte      = i_m_tdata[7:0];
                got.fill_level    = i_m_tdata[17:8];
                got.messages_held = i_m_tdata[25:18];
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected: status %0d, out_byte %0d",
                           got.status, got.out_byte);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    check_field("status", want.status, got.status);
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("last_byte", want.last_byte, got.last_byte);
                    check_field("zero_length", want.zero_length, got.zero_length);
                    check_field("fill_level", want.fill_level, got.fill_level);
                    check_field("messages_held", want.messages_held, got.messages_held);
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_request(i_s_tuser[1:0], i_s_tdata[6:0], i_s_tdata[14:7]);
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

>>> test/tb_top.sv
// Testbench top for the message ring: clock, reset, request stimulus, result stalls, verdict.
module tb_top;
    import lpmr_pkg::*;

    localparam int STALL_MAX    = 12;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 80;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [S_USER_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tlast;

    int fail_count;
    int pending;
    int checked;
    int idle_cycles = 0;
    int n_start = 0;
    int n_push = 0;
    int n_get = 0;
    int n_nop = 0;
    bit s_steady = 1'b0;
    bit m_steady = 1'b0;

    length_prefixed_message_ring_unit uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    lpmr_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // watchdog: too long without any handshake means the block hung
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stall before each result, with stretches of none
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 29) == 0) m_steady = !m_steady;
            stall = m_steady ? 0 : $urandom_range(0, STALL_MAX);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task automatic send_req(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                            input logic [BYTE_W-1:0] data);
        int gap;
        if ($urandom_range(0, 29) == 0) s_steady = !s_steady;
        gap = s_steady ? 0 : $urandom_range(0, STALL_MAX);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, data, len};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        case (op)
            OP_START: n_start++;
            OP_PUSH:  n_push++;
            OP_GET:   n_get++;
            default:  n_nop++;
        endcase
    endtask

    // start plus its data bytes; with glitch_pct, gets and starts land mid-message
    task automatic send_message(input int len, input int glitch_pct);
        int k;
        send_req(OP_START, LEN_W'(len), BYTE_W'($urandom));
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < glitch_pct)
                send_req($urandom_range(0, 1) ? OP_GET : OP_START,
                         LEN_W'($urandom_range(0, 16)), '0);
            send_req(OP_PUSH, '0, BYTE_W'($urandom));
        end
    endtask

    initial begin
        int pick;
        int len;
        int rand_base;
        int noise;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty get, no-op, stray byte, zero length, oversized, open start
        send_req(OP_GET, '0, '0);
        send_req(OP_NOP, '1, '1);
        send_req(OP_PUSH, '0, 8'hFF);
        send_req(OP_START, '0, '0);
        send_req(OP_GET, '0, '0);
        send_req(OP_START, 7'd127, '0);
        send_req(OP_PUSH, '0, 8'h00);
        send_req(OP_PUSH, '0, 8'hAA);
        send_req(OP_START, 7'd3, '0);
        send_req(OP_START, 7'd1, '0);
        send_req(OP_PUSH, '0, 8'hFF);
        send_req(OP_PUSH, '0, 8'h00);
        send_req(OP_PUSH, '0, 8'h5A);
        send_req(OP_GET, '0, '0);
        send_req(OP_GET, '0, '0);
        send_req(OP_START, 7'd65, '0);
        send_req(OP_START, 7'd1, '0);
        send_req(OP_PUSH, '0, 8'h81);
        send_req(OP_GET, '0, '0);

        // random: mostly whole messages and gets, some broken sequences and noise
        rand_base = n_start + n_push + n_get + n_nop;
        noise = 0;
        while (n_start + n_push + n_get + n_nop - rand_base - noise < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, MAX_MSG)
                                                  : $urandom_range(0, 16);
                send_message(len, 4);
            end else if (pick < 75) begin
                send_req(OP_GET, LEN_W'($urandom), BYTE_W'($urandom));
            end else if (pick < 83) begin
                len = $urandom_range(1, 16);
                send_req(OP_START, LEN_W'(len), '0);
                repeat ($urandom_range(0, len - 1)) send_req(OP_PUSH, '0, BYTE_W'($urandom));
            end else if (pick < 90) begin
                send_req(OP_START, LEN_W'($urandom_range(MAX_MSG + 1, 127)), '0);
                repeat ($urandom_range(0, 4)) send_req(OP_PUSH, '0, BYTE_W'($urandom));
            end else begin
                send_req($urandom_range(0, 1) ? OP_NOP : OP_PUSH,
                         LEN_W'($urandom), BYTE_W'($urandom));
                noise++;
            end
        end
        repeat (8) send_req(OP_GET, '0, '0);
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Requests: %0d starts, %0d pushes, %0d gets, %0d no-ops (drops, rejects, stalls)",
                 n_start, n_push, n_get, n_nop);
        $display("Results compared: %0d, mismatches: %0d", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
sv/lpmr_pkg.sv
sv/lpmr_ctrl.sv
sv/lpmr_dp.sv
sv/length_prefixed_message_ring_unit.sv
test/lpmr_checker.sv
test/tb_top.sv
